[hdl/ffra_pkg.sv]
`default_nettype none
package ffra_pkg;
   localparam int ADDR_W      = 38;
   localparam int BYTES_W     = 39;
   localparam int SIZE_W      = ADDR_W + 2;
   localparam int SUM_W       = SIZE_W + 1;
   localparam int FRAME_SHIFT = 12;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } region_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] grant;
      logic [1:0]        status;
   } result_type;

   function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W-1] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
   endfunction
endpackage
`default_nettype wire

[hdl/ffra_mem.sv]
`default_nettype none
module ffra_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 78
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[hdl/ffra_ctrl.sv]
`default_nettype none
module ffra_ctrl #(
   parameter int NUM_REGIONS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_cmd,
   input  wire logic [ffra_pkg::ADDR_W-1:0]     req_addr,
   input  wire logic [ffra_pkg::BYTES_W-1:0]    req_bytes,
   input  wire logic                            rsp_free,
   output      ffra_pkg::result_type            result,
   output      logic                            mem_wr_en,
   output      logic [$clog2(NUM_REGIONS)-1:0]  mem_wr_addr,
   output      ffra_pkg::region_type            mem_wr_data,
   output      logic [$clog2(NUM_REGIONS)-1:0]  mem_rd_addr,
   input  wire ffra_pkg::region_type            mem_rd_data
);
   localparam int IW = $clog2(NUM_REGIONS);
   localparam int CW = $clog2(NUM_REGIONS + 1);
   localparam int AW = ffra_pkg::ADDR_W;
   localparam int SW = ffra_pkg::SIZE_W;
   localparam int UW = ffra_pkg::SUM_W;
   localparam int FS = ffra_pkg::FRAME_SHIFT;
   localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_REGIONS);

   typedef enum logic [2:0] {IDLE, RD, CHK, RD2, CHK2, WR2, DONE} state_type;

   state_type        state_ff, state_in;
   logic             cmd_ff;
   logic [AW-1:0]    addr_ff;
   logic [SW-1:0]    len_ff;
   logic [UW-1:0]    fend_ff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    hit_ff, hit_in;
   logic [AW-1:0]    cs_ff, cs_in;
   logic [SW-1:0]    nsize_ff, nsize_in;
   logic [AW-1:0]    jstart_ff, jstart_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             init0_ff, init0_in;
   logic [AW-1:0]    grant_ff, grant_in;
   logic [1:0]       status_ff, status_in;

   ffra_pkg::region_type ent;
   logic [SW-1:0]    len_new;
   logic [SW-1:0]    sum_len;
   logic [UW-1:0]    ent_end;
   logic [UW-1:0]    grow_end;
   logic             last;

   always_comb begin
      if (idx_ff == '0 && init0_ff) begin
         ent.start = '0;
         ent.size  = SW'(1) << AW;
      end else begin
         ent = mem_rd_data;
      end
   end

   assign len_new  = ((SW'(req_bytes) + SW'((1 << FS) - 1)) >> FS) << FS;
   assign sum_len  = ffra_pkg::sat_add(ent.size, len_ff);
   assign ent_end  = UW'(ent.start) + UW'(ent.size);
   assign grow_end = UW'(cs_ff) + UW'(nsize_ff);
   assign last     = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign mem_rd_addr = idx_ff;
   assign req_stall   = (state_ff != IDLE);
   assign result.valid  = (state_ff == DONE) && rsp_free;
   assign result.grant  = grant_ff;
   assign result.status = status_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      cs_in       = cs_ff;
      nsize_in    = nsize_ff;
      jstart_in   = jstart_ff;
      count_in    = count_ff;
      grant_in    = grant_ff;
      status_in   = status_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = ent;
      unique case (state_ff)
         IDLE: begin
            idx_in    = '0;
            grant_in  = '0;
            status_in = ffra_pkg::ST_OK;
            if (req_valid) begin
               state_in = RD;
            end
         end
         RD: state_in = CHK;
         CHK: begin
            if (cmd_ff == ffra_pkg::CMD_ALLOC) begin
               if (ent.size != '0 && ent.size >= len_ff) begin
                  grant_in  = ent.start;
                  mem_wr_en = 1'b1;
                  if (ent.size == len_ff) begin
                     mem_wr_data.size = '0;
                  end else begin
                     mem_wr_data.start = ent.start + len_ff[AW-1:0];
                     mem_wr_data.size  = ent.size - len_ff;
                  end
                  state_in = DONE;
               end else if (last) begin
                  status_in = ffra_pkg::ST_NO_FIT;
                  state_in  = DONE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = RD;
               end
            end else begin
               if (ent.size != '0 && fend_ff == UW'(ent.start)) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_data.start = addr_ff;
                  mem_wr_data.size  = sum_len;
                  state_in          = DONE;
               end else if (ent.size != '0 && ent_end == UW'(addr_ff)) begin
                  hit_in   = idx_ff;
                  cs_in    = ent.start;
                  nsize_in = sum_len;
                  idx_in   = '0;
                  state_in = RD2;
               end else if (last) begin
                  if (count_ff == FULL_COUNT) begin
                     status_in = ffra_pkg::ST_FULL;
                  end else begin
                     mem_wr_en         = 1'b1;
                     mem_wr_addr       = count_ff[IW-1:0];
                     mem_wr_data.start = addr_ff;
                     mem_wr_data.size  = len_ff;
                     count_in          = count_ff + CW'(1);
                  end
                  state_in = DONE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = RD;
               end
            end
         end
         RD2: state_in = CHK2;
         CHK2: begin
            mem_wr_addr       = hit_ff;
            mem_wr_data.start = cs_ff;
            mem_wr_data.size  = nsize_ff;
            if (idx_ff != hit_ff && ent.size != '0 && grow_end == UW'(ent.start)) begin
               mem_wr_en        = 1'b1;
               mem_wr_data.size = ffra_pkg::sat_add(nsize_ff, ent.size);
               jstart_in        = ent.start;
               state_in         = WR2;
            end else if (last) begin
               mem_wr_en = 1'b1;
               state_in  = DONE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = RD2;
            end
         end
         WR2: begin
            mem_wr_en         = 1'b1;
            mem_wr_data.start = jstart_ff;
            mem_wr_data.size  = '0;
            state_in          = DONE;
         end
         DONE: begin
            if (rsp_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      init0_in = init0_ff && !(mem_wr_en && mem_wr_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= CW'(1);
         init0_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         init0_ff <= init0_in;
      end
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      cs_ff     <= cs_in;
      nsize_ff  <= nsize_in;
      jstart_ff <= jstart_in;
      grant_ff  <= grant_in;
      status_ff <= status_in;
      if (state_ff == IDLE && req_valid) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_addr;
         len_ff  <= len_new;
         fend_ff <= UW'(req_addr) + UW'(len_new);
      end
   end
endmodule
`default_nettype wire

[hdl/first_fit_region_allocator_top.sv]
// Scan: an allocate reads the table entries in order until the first fit; a free
// scans for an adjacent region, then may rescan the table to merge a following one.
// Flow: one item at a time; the next item is accepted only after the result
// is registered and the controller is back in idle, with one region memory read
// per table entry scanned.
// Reset: synchronous; the table holds one region covering the whole space.
`default_nettype none
module first_fit_region_allocator_top #(
   parameter int NUM_REGIONS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [ffra_pkg::ADDR_W-1:0]   req_addr,
   input  wire logic [ffra_pkg::BYTES_W-1:0]  req_bytes,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [ffra_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output      logic [1:0]                    rsp_status
);
   localparam int IW = $clog2(NUM_REGIONS);

   ffra_pkg::result_type  result;
   ffra_pkg::region_type  wr_data, rd_data;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic                  rsp_valid_ff;
   logic [ffra_pkg::ADDR_W-1:0] grant_ff;
   logic [1:0]            status_ff;
   logic                  rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   ffra_ctrl #(.NUM_REGIONS(NUM_REGIONS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_addr(req_addr), .req_bytes(req_bytes),
      .rsp_free(rsp_free), .result(result),
      .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_data(wr_data),
      .mem_rd_addr(rd_addr), .mem_rd_data(rd_data)
   );

   ffra_mem #(.DEPTH(NUM_REGIONS), .WIDTH($bits(ffra_pkg::region_type))) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid) begin
         grant_ff  <= result.grant;
         status_ff <= result.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grant_addr = grant_ff;
   assign rsp_status     = status_ff;
endmodule
`default_nettype wire

[hdl/ffra_checker.sv]
`default_nettype none
module ffra_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [37:0] rsp_grant_addr,
   input wire logic [1:0]  rsp_status
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("item dropped while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");
   a_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffra_pkg::ST_OK |-> rsp_grant_addr == '0)
      else $error("grant on failure");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");
endmodule

bind first_fit_region_allocator_top ffra_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_grant_addr(rsp_grant_addr), .rsp_status(rsp_status)
);
`default_nettype wire

[tb/tb_first_fit_region_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_region_allocator_top;

   localparam int NREG  = 64;
   localparam int FRAME = 4096;
   localparam int AW    = ffra_pkg::ADDR_W;
   localparam int BW    = ffra_pkg::BYTES_W;
   localparam int SW    = ffra_pkg::SIZE_W;
   localparam logic [SW-1:0] SIZE_MAX = {SW{1'b1}};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_cmd;
   logic [AW-1:0]       req_addr;
   logic [BW-1:0]       req_bytes;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [AW-1:0]       rsp_grant_addr;
   logic [1:0]          rsp_status;

   first_fit_region_allocator_top #(.NUM_REGIONS(NREG)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_addr(req_addr), .req_bytes(req_bytes),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_grant_addr(rsp_grant_addr), .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // shadow free-region table
   logic [AW-1:0] tbl_start [NREG];
   logic [SW-1:0] tbl_size [NREG];
   int            tbl_count;

   typedef struct {
      logic [AW-1:0] grant;
      logic [1:0]    status;
   } outcome_type;

   outcome_type pending_q[$];
   int          errors;
   int          sender_idle_pct;
   int          receiver_idle_pct;

   typedef struct {
      logic          cmd;
      logic [AW-1:0] addr;
      logic [BW-1:0] bytes;
      bit            typed;
      logic [AW-1:0] grant;
      logic [1:0]    status;
   } row_type;

   // live allocations for well-formed frees
   logic [AW-1:0] held_addr[$];
   logic [SW-1:0] held_len[$];

   function automatic logic [SW-1:0] frame_round(logic [BW-1:0] b);
      logic [SW-1:0] w;
      w = SW'(b) + SW'(FRAME - 1);
      return (w / FRAME) * FRAME;
   endfunction

   function automatic logic [SW-1:0] clamp_sum(logic [SW:0] s);
      return (s > {1'b0, SIZE_MAX}) ? SIZE_MAX : s[SW-1:0];
   endfunction

   function automatic outcome_type predict_allocation(logic cmd, logic [AW-1:0] addr,
                                                      logic [BW-1:0] bytes);
      outcome_type o;
      logic [SW-1:0] len;
      logic [SW:0] fend, ce;
      bit done;
      len = frame_round(bytes);
      o.grant = '0;
      o.status = ffra_pkg::ST_NO_FIT;
      done = 0;
      if (cmd == ffra_pkg::CMD_ALLOC) begin
         for (int i = 0; i < tbl_count && !done; i++) begin
            if (tbl_size[i] != 0 && tbl_size[i] >= len) begin
               o.grant = tbl_start[i];
               o.status = ffra_pkg::ST_OK;
               if (tbl_size[i] == len) tbl_size[i] = '0;
               else begin
                  tbl_start[i] = tbl_start[i] + AW'(len);
                  tbl_size[i] = tbl_size[i] - len;
               end
               done = 1;
            end
         end
         return o;
      end
      o.status = ffra_pkg::ST_OK;
      fend = (SW+1)'(addr) + (SW+1)'(len);
      for (int i = 0; i < tbl_count && !done; i++) begin
         ce = (SW+1)'(tbl_start[i]) + (SW+1)'(tbl_size[i]);
         if (tbl_size[i] != 0) begin
            if (fend == (SW+1)'(tbl_start[i])) begin
               tbl_start[i] = addr;
               tbl_size[i] = clamp_sum({1'b0, tbl_size[i]} + (SW+1)'(len));
               done = 1;
            end else if (ce == (SW+1)'(addr)) begin
               tbl_size[i] = clamp_sum({1'b0, tbl_size[i]} + (SW+1)'(len));
               for (int j = 0; j < tbl_count; j++) begin
                  if (j != i && tbl_size[j] != 0 &&
                      (SW+1)'(tbl_start[i]) + (SW+1)'(tbl_size[i]) ==
                      (SW+1)'(tbl_start[j])) begin
                     tbl_size[i] = clamp_sum({1'b0, tbl_size[i]} + (SW+1)'(tbl_size[j]));
                     tbl_size[j] = '0;
                     break;
                  end
               end
               done = 1;
            end
         end
      end
      if (!done) begin
         if (tbl_count >= NREG) o.status = ffra_pkg::ST_FULL;
         else begin
            tbl_start[tbl_count] = addr;
            tbl_size[tbl_count] = len;
            tbl_count++;
         end
      end
      return o;
   endfunction

   task automatic send_item(logic cmd, logic [AW-1:0] addr, logic [BW-1:0] bytes,
                            bit typed, logic [AW-1:0] g, logic [1:0] st);
      outcome_type o;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_addr  <= addr;
      req_bytes <= bytes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      o = predict_allocation(cmd, addr, bytes);
      if (typed && (o.grant !== g || o.status !== st)) begin
         $display("%0t directed row disagrees with predictor: exp %h/%0d pred %h/%0d",
                  $time, g, st, o.grant, o.status);
         errors++;
      end
      if (typed) begin
         o.grant = g;
         o.status = st;
      end
      pending_q.insert(pending_q.size(), o);
      if (cmd == ffra_pkg::CMD_ALLOC && o.status == ffra_pkg::ST_OK && bytes != 0) begin
         held_addr.insert(held_addr.size(), o.grant);
         held_len.insert(held_len.size(), frame_round(bytes));
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               $display("%0t unexpected result: grant %h status %0d",
                        $time, rsp_grant_addr, rsp_status);
               errors++;
            end else begin
               e = pending_q.pop_front();
               if (rsp_grant_addr !== e.grant) begin
                  $display("%0t grant_addr mismatch: expected %h actual %h",
                           $time, e.grant, rsp_grant_addr);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $display("%0t status mismatch: expected %0d actual %0d",
                           $time, e.status, rsp_status);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   row_type directed[$];

   task automatic add_row(logic cmd, logic [AW-1:0] a, logic [BW-1:0] b,
                          bit typed = 0, logic [AW-1:0] g = '0,
                          logic [1:0] st = ffra_pkg::ST_OK);
      row_type r;
      r.cmd = cmd; r.addr = a; r.bytes = b; r.typed = typed; r.grant = g; r.status = st;
      directed.insert(directed.size(), r);
   endtask

   task automatic random_item();
      int pick;
      int k;
      logic [BW-1:0] b;
      pick = $urandom_range(99);
      if (pick < 40) begin
         b = ($urandom_range(3) == 0) ? BW'({$urandom, $urandom}) :
                                        BW'($urandom_range(40000));
         if ($urandom_range(49) == 0) b = BW'(1) << 38;
         send_item(ffra_pkg::CMD_ALLOC, AW'({$urandom, $urandom}), b, 0, '0,
                   ffra_pkg::ST_OK);
      end else if (pick < 85 && held_addr.size() > 0) begin
         k = $urandom_range(held_addr.size() - 1);
         send_item(ffra_pkg::CMD_FREE, held_addr[k],
                   BW'(held_len[k]) - BW'($urandom_range(FRAME - 1)),
                   0, '0, ffra_pkg::ST_OK);
         held_addr.delete(k);
         held_len.delete(k);
      end else begin
         b = ($urandom_range(1)) ? BW'({$urandom, $urandom}) : BW'($urandom_range(20000));
         send_item(ffra_pkg::CMD_FREE, AW'({$urandom, $urandom}), b, 0, '0,
                   ffra_pkg::ST_OK);
      end
   endtask

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int guard;
      errors = 0;
      tbl_count = 1;
      tbl_start[0] = '0;
      tbl_size[0] = SW'(1) << AW;
      for (int i = 1; i < NREG; i++) begin
         tbl_start[i] = '0;
         tbl_size[i] = '0;
      end
      sender_idle_pct = 13;
      receiver_idle_pct = 67;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = ffra_pkg::CMD_ALLOC;
      req_addr = '0;
      req_bytes = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(ffra_pkg::CMD_ALLOC, '0, '0, 1, '0, ffra_pkg::ST_OK);
      add_row(ffra_pkg::CMD_ALLOC, '1, 1, 1, '0, ffra_pkg::ST_OK);
      add_row(ffra_pkg::CMD_ALLOC, '0, 4096, 1, 38'h1000, ffra_pkg::ST_OK);
      add_row(ffra_pkg::CMD_ALLOC, '0, '1, 1, '0, ffra_pkg::ST_NO_FIT);
      add_row(ffra_pkg::CMD_ALLOC, '0, 4097, 1, 38'h2000, ffra_pkg::ST_OK);
      add_row(ffra_pkg::CMD_FREE, 38'h1000, 4096);
      add_row(ffra_pkg::CMD_FREE, '0, 100);
      add_row(ffra_pkg::CMD_ALLOC, '0, 8192, 1, 38'h4000, ffra_pkg::ST_OK);
      add_row(ffra_pkg::CMD_FREE, 38'h10_0000, 0);
      add_row(ffra_pkg::CMD_FREE, 38'h2000, 8192);
      add_row(ffra_pkg::CMD_FREE, 38'h3F_FFFF_F000, 4096);
      add_row(ffra_pkg::CMD_FREE, '1, 39'h40_0000_0000);
      add_row(ffra_pkg::CMD_FREE, '0, '1);
      add_row(ffra_pkg::CMD_ALLOC, '0, 39'h40_0000_0000);
      add_row(ffra_pkg::CMD_ALLOC, '0, 12288);
      foreach (directed[i])
         send_item(directed[i].cmd, directed[i].addr, directed[i].bytes,
                   directed[i].typed, directed[i].grant, directed[i].status);
      // fill the table to reach the full case
      for (int i = 0; i < NREG + 2; i++)
         send_item(ffra_pkg::CMD_FREE, AW'(64'h20_0000_0000 + i * 64'h10_0000), 4096,
                   0, '0, ffra_pkg::ST_OK);

      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin sender_idle_pct = 67; receiver_idle_pct = 13; end
         if (p == 2) begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
         for (int n = 0; n < 610; n++) random_item();
      end
      req_valid <= 1'b0;

      guard = 0;
      while (pending_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (600) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
hdl/ffra_pkg.sv
hdl/ffra_mem.sv
hdl/ffra_ctrl.sv
hdl/first_fit_region_allocator_top.sv
hdl/ffra_checker.sv
tb/tb_first_fit_region_allocator_top.sv
